FILE: hdl/bqem_pkg.sv
`default_nettype none

package bqem_pkg;

  localparam int NODE_COUNT = 4;
  localparam int ROW_W      = $clog2(NODE_COUNT);

  localparam int COORD_W = 24;
  localparam int G_W     = 18;
  localparam int CP_W    = COORD_W + G_W;
  localparam int R_W     = CP_W + 2;
  localparam int J_W     = 25;
  localparam int DP_W    = 2 * J_W;
  localparam int T_W     = J_W + G_W;
  localparam int AD_W    = 48;
  localparam int D24_W   = 40;
  localparam int HALF_W  = D24_W / 2;
  localparam int NI_W    = 16;
  localparam int B_W     = 25;
  localparam int N_W     = 2 * B_W;
  localparam int ACC_W   = 64;
  localparam int RES_W   = 32;

  // quotient: integer part up to the clamp, then the rounding fraction bits
  localparam int CLAMP_SH  = 24;
  localparam int DIV_FRAC  = 17;
  localparam int DIV_STEPS = CLAMP_SH + DIV_FRAC;
  localparam int Q_W       = DIV_STEPS + 1;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam int GAUSS_Q16 = 37837;
  localparam int ONE_Q16   = 65536;
  localparam int G_HI      = ONE_Q16 + GAUSS_Q16;
  localparam int G_LO      = ONE_Q16 - GAUSS_Q16;

  localparam longint NI_HH = (longint'(G_HI) * longint'(G_HI) + 64'sd131072) >>> 18;
  localparam longint NI_HL = (longint'(G_HI) * longint'(G_LO) + 64'sd131072) >>> 18;
  localparam longint NI_LL = (longint'(G_LO) * longint'(G_LO) + 64'sd131072) >>> 18;

  typedef logic [1:0] pt_t;

  typedef struct packed {
    logic                              sing;
    logic [AD_W-1:0]                   ad;
    logic [D24_W-1:0]                  d24;
    logic [NODE_COUNT-1:0][NI_W-1:0]   ni;
    logic [NODE_COUNT-1:0][B_W-1:0]    bx;
    logic [NODE_COUNT-1:0][B_W-1:0]    by;
  } geo_t;

  typedef struct packed {
    logic clr;
    logic start;
    logic op;
  } lane_ctl_t;

  function automatic logic signed [G_W-1:0] g_term(logic hi, logic pos);
    logic signed [G_W-1:0] m;
    m = hi ? G_W'(G_HI) : G_W'(G_LO);
    return pos ? m : -m;
  endfunction

  // reference x-gradient of node k at point p, times 4, q16
  function automatic logic signed [G_W-1:0] ga_of(logic [1:0] k, pt_t p);
    return g_term(k[1] == p[1], k[0]);
  endfunction

  function automatic logic signed [G_W-1:0] gb_of(logic [1:0] k, pt_t p);
    return g_term(k[0] == p[0], k[1]);
  endfunction

  function automatic logic [NI_W-1:0] ni_of(logic [1:0] k, pt_t p);
    logic [NI_W-1:0] v;
    case ({k[0] == p[0], k[1] == p[1]})
      2'b11:   v = NI_W'(NI_HH);
      2'b00:   v = NI_W'(NI_LL);
      default: v = NI_W'(NI_HL);
    endcase
    return v;
  endfunction

  // round half away from zero, then shift right by n
  function automatic logic signed [63:0] rnd64(logic signed [63:0] v, int n);
    logic signed [63:0] h;
    logic signed [63:0] c;
    h = 64'sd1 <<< (n - 1);
    c = v[63] ? 64'sd1 : 64'sd0;
    return (v + h - c) >>> n;
  endfunction

  function automatic logic [RES_W-1:0] sat32(logic signed [63:0] v);
    logic [RES_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[RES_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/bqem_geom.sv
`default_nettype none

module bqem_geom (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                start_i,
  input  bqem_pkg::pt_t                                       pt_i,
  input  logic [bqem_pkg::NODE_COUNT-1:0][bqem_pkg::COORD_W-1:0] xs_i,
  input  logic [bqem_pkg::NODE_COUNT-1:0][bqem_pkg::COORD_W-1:0] ys_i,
  output logic                                                vld_o,
  output bqem_pkg::geo_t                                      geo_o
);
  import bqem_pkg::*;

  logic [3:0] vld_q;
  pt_t pt1_q, pt2_q, pt3_q;

  logic signed [R_W-1:0] r11_d, r12_d, r21_d, r22_d;
  logic signed [R_W-1:0] r11_q, r12_q, r21_q, r22_q;
  logic signed [J_W-1:0] j11_q, j12_q, j21_q, j22_q;
  logic signed [DP_W-1:0] dp1_q, dp2_q;
  logic signed [T_W-1:0] ta_q [NODE_COUNT];
  logic signed [T_W-1:0] tb_q [NODE_COUNT];
  logic signed [T_W-1:0] ua_q [NODE_COUNT];
  logic signed [T_W-1:0] ub_q [NODE_COUNT];
  geo_t geo_d, geo_q;

  // stage 1: jacobian sums
  always_comb begin
    logic signed [COORD_W-1:0] x, y;
    logic signed [G_W-1:0] a, b;
    logic signed [CP_W-1:0] pxa, pxb, pya, pyb;
    r11_d = '0;
    r12_d = '0;
    r21_d = '0;
    r22_d = '0;
    for (int k = 0; k < NODE_COUNT; k++) begin
      x   = xs_i[k];
      y   = ys_i[k];
      a   = ga_of(2'(k), pt_i);
      b   = gb_of(2'(k), pt_i);
      pxa = x * a;
      pxb = x * b;
      pya = y * a;
      pyb = y * b;
      r11_d = r11_d + pxa;
      r12_d = r12_d + pxb;
      r21_d = r21_d + pya;
      r22_d = r22_d + pyb;
    end
  end

  // stage 4: determinant and physical gradients
  always_comb begin
    logic signed [DP_W:0] d;
    logic [DP_W:0] dm;
    logic [AD_W-1:0] ad;
    logic [AD_W-1:0] ads;
    logic signed [63:0] dx, dy, rx, ry;
    d   = dp1_q - dp2_q;
    dm  = d[DP_W] ? -d : d;
    ad  = dm[AD_W-1:0];
    ads = ad + AD_W'(128);
    geo_d      = geo_q;
    geo_d.sing = (d == '0);
    geo_d.ad   = ad;
    geo_d.d24  = ads[AD_W-1:8];
    for (int k = 0; k < NODE_COUNT; k++) begin
      dx = ta_q[k] - tb_q[k];
      dy = ub_q[k] - ua_q[k];
      rx = rnd64(dx, 18);
      ry = rnd64(dy, 18);
      geo_d.bx[k] = rx[B_W-1:0];
      geo_d.by[k] = ry[B_W-1:0];
      geo_d.ni[k] = ni_of(2'(k), pt3_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [63:0] t11, t12, t21, t22;
    t11 = rnd64(r11_q, 18);
    t12 = rnd64(r12_q, 18);
    t21 = rnd64(r21_q, 18);
    t22 = rnd64(r22_q, 18);
    if (start_i) begin
      r11_q <= r11_d;
      r12_q <= r12_d;
      r21_q <= r21_d;
      r22_q <= r22_d;
      pt1_q <= pt_i;
    end
    if (vld_q[0]) begin
      j11_q <= t11[J_W-1:0];
      j12_q <= t12[J_W-1:0];
      j21_q <= t21[J_W-1:0];
      j22_q <= t22[J_W-1:0];
      pt2_q <= pt1_q;
    end
    if (vld_q[1]) begin
      dp1_q <= j11_q * j22_q;
      dp2_q <= j12_q * j21_q;
      for (int k = 0; k < NODE_COUNT; k++) begin
        ta_q[k] <= j22_q * ga_of(2'(k), pt2_q);
        tb_q[k] <= j21_q * gb_of(2'(k), pt2_q);
        ua_q[k] <= j12_q * ga_of(2'(k), pt2_q);
        ub_q[k] <= j11_q * gb_of(2'(k), pt2_q);
      end
      pt3_q <= pt2_q;
    end
    if (vld_q[2]) begin
      geo_q <= geo_d;
    end
  end

  assign vld_o = vld_q[3];
  assign geo_o = geo_q;

endmodule

`default_nettype wire

FILE: hdl/bqem_lane.sv
`default_nettype none

module bqem_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bqem_pkg::lane_ctl_t                 ctl_i,
  input  logic [bqem_pkg::AD_W-1:0]           ad_i,
  input  logic [bqem_pkg::D24_W-1:0]          d24_i,
  input  logic [bqem_pkg::NI_W-1:0]           ni_a_i,
  input  logic [bqem_pkg::NI_W-1:0]           ni_b_i,
  input  logic signed [bqem_pkg::B_W-1:0]     bx_a_i,
  input  logic signed [bqem_pkg::B_W-1:0]     bx_b_i,
  input  logic signed [bqem_pkg::B_W-1:0]     by_a_i,
  input  logic signed [bqem_pkg::B_W-1:0]     by_b_i,
  output logic                                busy_o,
  output logic [bqem_pkg::RES_W-1:0]          res_o
);
  import bqem_pkg::*;

  typedef enum logic [6:0] {
    L_IDLE = 7'b0000001,
    L_PROD = 7'b0000010,
    L_MLO  = 7'b0000100,
    L_MHI  = 7'b0001000,
    L_DSET = 7'b0010000,
    L_DIV  = 7'b0100000,
    L_DACC = 7'b1000000
  } lane_state_e;

  lane_state_e state_d, state_q;
  logic [NI_W-1:0] nn_d, nn_q;
  logic signed [N_W-1:0] n_d, n_q;
  logic neg_d, neg_q;
  logic [AD_W-1:0] rem_d, rem_q;
  logic [DIV_STEPS-1:0] dvd_d, dvd_q;
  logic [Q_W-1:0] q_d, q_q;
  logic [CNT_W-1:0] cnt_d, cnt_q;
  logic signed [ACC_W-1:0] acc_d, acc_q;

  always_comb begin
    logic [2*NI_W-1:0] pn;
    logic [NI_W+HALF_W-1:0] pm;
    logic signed [N_W-1:0] px, py;
    logic [N_W-1:0] mag;
    logic [AD_W:0] r2;
    logic ge;
    logic [Q_W-1:0] c;
    logic signed [ACC_W-1:0] cext;
    state_d = state_q;
    nn_d    = nn_q;
    n_d     = n_q;
    neg_d   = neg_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    q_d     = q_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    pn      = ni_a_i * ni_b_i + (2*NI_W)'(32768);
    px      = bx_a_i * bx_b_i;
    py      = by_a_i * by_b_i;
    mag     = n_q[N_W-1] ? -n_q : n_q;
    r2      = {rem_q, dvd_q[DIV_STEPS-1]};
    ge      = r2 >= {1'b0, ad_i};
    c       = (q_q + Q_W'(1)) >> 1;
    cext    = signed'(ACC_W'(c));
    pm      = '0;
    case (state_q)
      L_IDLE: begin
        if (ctl_i.start) state_d = L_PROD;
      end
      L_PROD: begin
        nn_d    = pn[2*NI_W-1:NI_W];
        n_d     = px + py;
        state_d = ctl_i.op ? L_DSET : L_MLO;
      end
      L_MLO: begin
        pm      = nn_q * d24_i[HALF_W-1:0];
        acc_d   = acc_q + signed'(ACC_W'(pm));
        state_d = L_MHI;
      end
      L_MHI: begin
        pm      = nn_q * d24_i[D24_W-1:HALF_W];
        acc_d   = acc_q + signed'(ACC_W'(pm) << HALF_W);
        state_d = L_IDLE;
      end
      L_DSET: begin
        neg_d = n_q[N_W-1];
        // ratio at or above the clamp: skip the division
        if (AD_W'(mag[AD_W-1:CLAMP_SH]) >= ad_i) begin
          q_d     = Q_W'(1) << DIV_STEPS;
          state_d = L_DACC;
        end else begin
          rem_d   = AD_W'(mag[AD_W-1:CLAMP_SH]);
          dvd_d   = {mag[CLAMP_SH-1:0], DIV_FRAC'(0)};
          q_d     = '0;
          cnt_d   = '0;
          state_d = L_DIV;
        end
      end
      L_DIV: begin
        rem_d = ge ? AD_W'(r2 - {1'b0, ad_i}) : r2[AD_W-1:0];
        dvd_d = dvd_q << 1;
        q_d   = {q_q[Q_W-2:0], ge};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = L_DACC;
      end
      L_DACC: begin
        acc_d   = neg_q ? acc_q + cext : acc_q - cext;
        state_d = L_IDLE;
      end
      default: state_d = L_IDLE;
    endcase
    if (ctl_i.clr) acc_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nn_q  <= nn_d;
    n_q   <= n_d;
    neg_q <= neg_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    q_q   <= q_d;
    cnt_q <= cnt_d;
    acc_q <= acc_d;
  end

  always_comb begin
    logic signed [63:0] rm;
    rm    = rnd64(acc_q, 24);
    res_o = ctl_i.op ? sat32(acc_q) : sat32(rm);
  end

  assign busy_o = (state_q != L_IDLE);

endmodule

`default_nettype wire

FILE: hdl/bqem_merge.sv
`default_nettype none

module bqem_merge (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 load_i,
  input  logic                                 sing_i,
  input  logic [bqem_pkg::NODE_COUNT-1:0][bqem_pkg::NODE_COUNT-1:0][bqem_pkg::RES_W-1:0] vals_i,
  output logic                                 free_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [bqem_pkg::ROW_W-1:0]           row_index_o,
  output logic [bqem_pkg::RES_W-1:0]           entry_col0_o,
  output logic [bqem_pkg::RES_W-1:0]           entry_col1_o,
  output logic [bqem_pkg::RES_W-1:0]           entry_col2_o,
  output logic [bqem_pkg::RES_W-1:0]           entry_col3_o,
  output logic                                 singular_flag_o,
  output logic                                 last_row_o
);
  import bqem_pkg::*;

  logic full_q;
  logic [ROW_W-1:0] row_q;
  logic sing_q;
  logic [NODE_COUNT-1:0][NODE_COUNT-1:0][RES_W-1:0] vals_q;
  logic out_acc;
  logic last;

  assign out_acc = full_q && !out_stall_i;
  assign last    = (row_q == ROW_W'(NODE_COUNT - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      row_q  <= '0;
    end else if (load_i) begin
      full_q <= 1'b1;
      row_q  <= '0;
    end else if (out_acc) begin
      row_q <= row_q + ROW_W'(1);
      if (last) full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      vals_q <= vals_i;
      sing_q <= sing_i;
    end
  end

  assign free_o          = !full_q;
  assign out_valid_o     = full_q;
  assign row_index_o     = row_q;
  assign entry_col0_o    = vals_q[row_q][0];
  assign entry_col1_o    = vals_q[row_q][1];
  assign entry_col2_o    = vals_q[row_q][2];
  assign entry_col3_o    = vals_q[row_q][3];
  assign singular_flag_o = sing_q;
  assign last_row_o      = last;

endmodule

`default_nettype wire

FILE: hdl/bilinear_quad_element_matrix.sv
// geometry runs once for each gauss point, then the 16 entry lanes run: for mass, a
// product and two half-width multiply-accumulates; for diffusion, a product, divider
// setup, the bit-serial divider and an accumulate; result rows leave one row per cycle
// unless out_stall_i is high; one element is buffered at the input and one at the output
// reset: asynchronous, active low; clears the sequencer, lane and output control state
`default_nettype none

module bilinear_quad_element_matrix (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               opcode_i,
  input  logic signed [bqem_pkg::COORD_W-1:0] node0_x_i,
  input  logic signed [bqem_pkg::COORD_W-1:0] node0_y_i,
  input  logic signed [bqem_pkg::COORD_W-1:0] node1_x_i,
  input  logic signed [bqem_pkg::COORD_W-1:0] node1_y_i,
  input  logic signed [bqem_pkg::COORD_W-1:0] node2_x_i,
  input  logic signed [bqem_pkg::COORD_W-1:0] node2_y_i,
  input  logic signed [bqem_pkg::COORD_W-1:0] node3_x_i,
  input  logic signed [bqem_pkg::COORD_W-1:0] node3_y_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [bqem_pkg::ROW_W-1:0]         row_index_o,
  output logic signed [bqem_pkg::RES_W-1:0]  entry_col0_o,
  output logic signed [bqem_pkg::RES_W-1:0]  entry_col1_o,
  output logic signed [bqem_pkg::RES_W-1:0]  entry_col2_o,
  output logic signed [bqem_pkg::RES_W-1:0]  entry_col3_o,
  output logic                               singular_flag_o,
  output logic                               last_row_o
);
  import bqem_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_GEOM = 4'b0010,
    S_LANE = 4'b0100,
    S_DONE = 4'b1000
  } seq_state_e;

  seq_state_e state_d, state_q;

  logic in_full_q;
  logic in_op_q;
  logic [NODE_COUNT-1:0][COORD_W-1:0] in_xs_q, in_ys_q;
  logic op_q;
  logic [NODE_COUNT-1:0][COORD_W-1:0] xs_q, ys_q;
  logic sing_d, sing_q;
  pt_t pt_d, pt_q;

  logic take, in_acc;
  logic geo_start, geo_vld;
  pt_t geo_pt;
  geo_t geo;
  lane_ctl_t lane_ctl;
  logic [NODE_COUNT*NODE_COUNT-1:0] lane_busy;
  logic [NODE_COUNT-1:0][NODE_COUNT-1:0][RES_W-1:0] vals;
  logic merge_free, merge_load;
  logic last_pt;

  assign take       = (state_q == S_IDLE) && in_full_q;
  assign in_stall_o = in_full_q && !(state_q == S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign last_pt    = (pt_q == pt_t'(NODE_COUNT - 1));

  always_comb begin
    state_d    = state_q;
    sing_d     = sing_q;
    pt_d       = pt_q;
    geo_start  = 1'b0;
    merge_load = 1'b0;
    lane_ctl   = '{clr: take, start: 1'b0, op: op_q};
    case (state_q)
      S_IDLE: begin
        if (in_full_q) begin
          sing_d    = 1'b0;
          pt_d      = '0;
          geo_start = 1'b1;
          state_d   = S_GEOM;
        end
      end
      S_GEOM: begin
        if (geo_vld) begin
          if (geo.sing) begin
            // a zero jacobian point adds nothing
            sing_d = 1'b1;
            if (last_pt) begin
              state_d = S_DONE;
            end else begin
              pt_d      = pt_q + pt_t'(1);
              geo_start = 1'b1;
            end
          end else begin
            lane_ctl.start = 1'b1;
            state_d        = S_LANE;
          end
        end
      end
      S_LANE: begin
        if (lane_busy == '0) begin
          if (last_pt) begin
            state_d = S_DONE;
          end else begin
            pt_d      = pt_q + pt_t'(1);
            geo_start = 1'b1;
            state_d   = S_GEOM;
          end
        end
      end
      S_DONE: begin
        if (merge_free) begin
          merge_load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign geo_pt = take ? pt_t'(0) : pt_q + pt_t'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      in_full_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        in_full_q <= 1'b1;
      end else if (take) begin
        in_full_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sing_q <= sing_d;
    pt_q   <= pt_d;
    if (in_acc) begin
      in_op_q    <= opcode_i;
      in_xs_q[0] <= node0_x_i;
      in_xs_q[1] <= node1_x_i;
      in_xs_q[2] <= node2_x_i;
      in_xs_q[3] <= node3_x_i;
      in_ys_q[0] <= node0_y_i;
      in_ys_q[1] <= node1_y_i;
      in_ys_q[2] <= node2_y_i;
      in_ys_q[3] <= node3_y_i;
    end
    if (take) begin
      op_q <= in_op_q;
      xs_q <= in_xs_q;
      ys_q <= in_ys_q;
    end
  end

  bqem_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (geo_start),
    .pt_i    (geo_pt),
    .xs_i    (take ? in_xs_q : xs_q),
    .ys_i    (take ? in_ys_q : ys_q),
    .vld_o   (geo_vld),
    .geo_o   (geo)
  );

  for (genvar r = 0; r < NODE_COUNT; r++) begin : g_row
    for (genvar c = 0; c < NODE_COUNT; c++) begin : g_col
      bqem_lane u_lane (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctl_i  (lane_ctl),
        .ad_i   (geo.ad),
        .d24_i  (geo.d24),
        .ni_a_i (geo.ni[r]),
        .ni_b_i (geo.ni[c]),
        .bx_a_i (geo.bx[r]),
        .bx_b_i (geo.bx[c]),
        .by_a_i (geo.by[r]),
        .by_b_i (geo.by[c]),
        .busy_o (lane_busy[r*NODE_COUNT+c]),
        .res_o  (vals[r][c])
      );
    end
  end

  bqem_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (merge_load),
    .sing_i          (sing_q),
    .vals_i          (vals),
    .free_o          (merge_free),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .row_index_o     (row_index_o),
    .entry_col0_o    (entry_col0_o),
    .entry_col1_o    (entry_col1_o),
    .entry_col2_o    (entry_col2_o),
    .entry_col3_o    (entry_col3_o),
    .singular_flag_o (singular_flag_o),
    .last_row_o      (last_row_o)
  );

endmodule

`default_nettype wire
